/* rtl/rrts_pkg.sv */
// shared types and codes for the round-robin time slicer
`default_nettype none
package rrts_pkg;

	localparam int IdW     = 8;
	localparam int BurstW  = 16;
	localparam int StatusW = 3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SLICE = 1'b1;

	localparam logic [StatusW-1:0] ST_LOADED   = 3'd0;
	localparam logic [StatusW-1:0] ST_REFUSED  = 3'd1;
	localparam logic [StatusW-1:0] ST_REQUEUED = 3'd2;
	localparam logic [StatusW-1:0] ST_FINISHED = 3'd3;
	localparam logic [StatusW-1:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic [IdW-1:0]    id;
		logic [BurstW-1:0] burst;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/rrts_if.sv */
// handshake channels of the round-robin time slicer
`default_nettype none
interface rrts_item_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  process_id;
	logic [15:0] burst_time;

	modport source (output valid, output opcode, output process_id, output burst_time,
		input ready);
	modport sink (input valid, input opcode, input process_id, input burst_time,
		output ready);
endinterface

interface rrts_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  served_id;
	logic [15:0] remaining_time;
	logic [2:0]  status;
	logic        queue_empty;

	modport source (output valid, output served_id, output remaining_time, output status,
		output queue_empty, input ready);
	modport sink (input valid, input served_id, input remaining_time, input status,
		input queue_empty, output ready);
endinterface

interface rrts_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] time_quantum;

	modport source (output valid, output time_quantum, input ready);
	modport sink (input valid, input time_quantum, output ready);
endinterface
`default_nettype wire

/* rtl/round_robin_time_slicer_core.sv */
// Round-robin time slicer: a ready queue of QUEUE_DEPTH (id, burst) slots built as a row of
// cells with the head in cell 0; a slice pops the head and every cell takes its neighbor's
// word in the same cycle, a load or a requeue writes the slot behind the last occupied one.
// Each accepted item's result appears in the output register in the cycle after acceptance;
// a new item is accepted every cycle as long as the result register is free or being
// drained, so throughput is one item per clock. The queue needs no clearing after
// reset. time_quantum resets to 1 and may be written whenever the block is idle.
`default_nettype none
module round_robin_time_slicer_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rrts_item_if.sink     item,
	rrts_result_if.source result,
	rrts_cfg_if.sink      cfg
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]                    count_q;
	logic [rrts_pkg::BurstW-1:0]      quantum_q;
	logic                             res_valid_q;
	logic [rrts_pkg::IdW-1:0]         res_id_q;
	logic [rrts_pkg::BurstW-1:0]      res_rem_q;
	logic [rrts_pkg::StatusW-1:0]     res_status_q;
	logic                             res_empty_q;

	rrts_pkg::entry_t    cells [QUEUE_DEPTH];
	rrts_pkg::entry_t    head;
	rrts_pkg::entry_t    push_data;
	rrts_pkg::cell_ctl_t ctl [QUEUE_DEPTH];

	logic                         accept;
	logic                         is_load;
	logic                         full;
	logic                         nonempty;
	logic                         do_load;
	logic                         do_pop;
	logic                         gt;
	logic                         requeue;
	logic                         push;
	logic [CW-1:0]                push_pos;
	logic [CW-1:0]                count_next;
	logic [rrts_pkg::BurstW-1:0]  diff;
	logic [rrts_pkg::IdW-1:0]     nx_id;
	logic [rrts_pkg::BurstW-1:0]  nx_rem;
	logic [rrts_pkg::StatusW-1:0] nx_status;

	assign item.ready = !res_valid_q || result.ready;
	assign cfg.ready  = 1'b1;
	assign accept     = item.valid && item.ready;

	assign head     = cells[0];
	assign is_load  = (item.opcode == rrts_pkg::OP_LOAD);
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign do_load  = accept && is_load && !full;
	assign do_pop   = accept && !is_load && nonempty;
	assign gt       = head.burst > quantum_q;
	assign diff     = head.burst - quantum_q;
	assign requeue  = do_pop && gt;
	assign push     = do_load || requeue;

	always_comb begin
		if (is_load) begin
			push_data.id    = item.process_id;
			push_data.burst = item.burst_time;
		end else begin
			push_data.id    = head.id;
			push_data.burst = diff;
		end
	end

	// after a pop the free slot sits one lower
	assign push_pos   = do_pop ? (count_q - CW'(1)) : count_q;
	assign count_next = count_q + CW'(push) - CW'(do_pop);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign ctl[i].shift = do_pop;
		assign ctl[i].load  = push && (push_pos == CW'(i));
		if (i == QUEUE_DEPTH - 1) begin : g_last
			rrts_cell u_cell (
				.clk (clk),
				.ctl (ctl[i]),
				.nxt (push_data),
				.din (push_data),
				.q   (cells[i])
			);
		end else begin : g_mid
			rrts_cell u_cell (
				.clk (clk),
				.ctl (ctl[i]),
				.nxt (cells[i+1]),
				.din (push_data),
				.q   (cells[i])
			);
		end
	end

	always_comb begin
		nx_id     = '0;
		nx_rem    = '0;
		nx_status = rrts_pkg::ST_EMPTY;
		if (is_load) begin
			nx_id     = item.process_id;
			nx_rem    = item.burst_time;
			nx_status = full ? rrts_pkg::ST_REFUSED : rrts_pkg::ST_LOADED;
		end else if (nonempty) begin
			nx_id     = head.id;
			nx_rem    = gt ? diff : head.burst;
			nx_status = gt ? rrts_pkg::ST_REQUEUED : rrts_pkg::ST_FINISHED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			quantum_q   <= rrts_pkg::BurstW'(1);
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				quantum_q <= cfg.time_quantum;
			end
			if (accept) begin
				count_q     <= count_next;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_id_q     <= nx_id;
			res_rem_q    <= nx_rem;
			res_status_q <= nx_status;
			res_empty_q  <= (count_next == '0);
		end
	end

	assign result.valid          = res_valid_q;
	assign result.served_id      = res_id_q;
	assign result.remaining_time = res_rem_q;
	assign result.status         = res_status_q;
	assign result.queue_empty    = res_empty_q;

endmodule
`default_nettype wire

/* rtl/rrts_cell.sv */
// one queue slot: loads a new word or takes its upper neighbor's word on a pop
`default_nettype none
module rrts_cell (
	input  wire logic               clk,
	input  wire rrts_pkg::cell_ctl_t ctl,
	input  wire rrts_pkg::entry_t   nxt,
	input  wire rrts_pkg::entry_t   din,
	output rrts_pkg::entry_t        q
);

	rrts_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= din;
		end else if (ctl.shift) begin
			entry_q <= nxt;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

/* rtl/rrts_checker.sv */
// port-level checks for the round-robin time slicer
`default_nettype none
module rrts_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  served_id,
	input wire logic [15:0] remaining_time,
	input wire logic [2:0]  status,
	input wire logic        queue_empty
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(served_id)
			&& $stable(remaining_time) && $stable(queue_empty))
		else $error("result word changed while stalled");

	// every accepted word yields a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word produced no result");

	// an empty-queue slice reports nothing
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rrts_pkg::ST_EMPTY
			|-> served_id == 8'd0 && remaining_time == 16'd0 && queue_empty)
		else $error("empty slice carries data");

	// a load, requeue or refusal leaves at least one process queued
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rrts_pkg::ST_REQUEUED || status == rrts_pkg::ST_REFUSED
			|| status == rrts_pkg::ST_LOADED) |-> !queue_empty)
		else $error("queue reported empty after a push");

endmodule

bind round_robin_time_slicer_core rrts_checker u_rrts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (item.valid),
	.in_ready       (item.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.served_id      (result.served_id),
	.remaining_time (result.remaining_time),
	.status         (result.status),
	.queue_empty    (result.queue_empty)
);
`default_nettype wire

/* bench/rrts_ledger_pkg.sv */
// expected-result ledger for the round-robin time slicer bench
package rrts_ledger_pkg;
	import rrts_pkg::*;

	typedef struct packed {
		logic [IdW-1:0]     served_id;
		logic [BurstW-1:0]  remaining_time;
		logic [StatusW-1:0] status;
		logic               queue_empty;
	} outcome_t;

	class slice_ledger;
		int                depth;
		logic [BurstW-1:0] quantum;
		entry_t            run_queue[$];
		outcome_t          due_results[$];
		int                fails;

		function new(int queue_depth);
			depth = queue_depth;
			quantum = 16'd1;
			fails = 0;
		endfunction

		function void set_quantum(logic [BurstW-1:0] value);
			quantum = value;
		endfunction

		function int occupancy();
			return run_queue.size();
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// one accepted word in, one outcome queued
		function void log_item(logic op, logic [IdW-1:0] pid, logic [BurstW-1:0] burst);
			outcome_t o;
			entry_t   e;
			o = '0;
			if (op == OP_LOAD) begin
				o.served_id = pid;
				o.remaining_time = burst;
				if (run_queue.size() >= depth) begin
					o.status = ST_REFUSED;
				end else begin
					e.id = pid;
					e.burst = burst;
					run_queue.insert(run_queue.size(), e);
					o.status = ST_LOADED;
				end
			end else if (run_queue.size() == 0) begin
				o.status = ST_EMPTY;
			end else begin
				e = run_queue.pop_front();
				o.served_id = e.id;
				if (e.burst > quantum) begin
					e.burst = e.burst - quantum;
					run_queue.insert(run_queue.size(), e);
					o.status = ST_REQUEUED;
				end else begin
					o.status = ST_FINISHED;
				end
				o.remaining_time = e.burst;
			end
			o.queue_empty = (run_queue.size() == 0);
			due_results.insert(due_results.size(), o);
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (due_results.size() == 0) begin
				$error("result word with nothing pending: served_id %0d status %0d",
					got.served_id, got.status);
				fails++;
				return;
			end
			want = due_results.pop_front();
			if (got.served_id !== want.served_id) begin
				$error("served_id expected %0d actual %0d", want.served_id, got.served_id);
				fails++;
			end
			if (got.remaining_time !== want.remaining_time) begin
				$error("remaining_time expected %0d actual %0d", want.remaining_time,
					got.remaining_time);
				fails++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				fails++;
			end
			if (got.queue_empty !== want.queue_empty) begin
				$error("queue_empty expected %0b actual %0b", want.queue_empty,
					got.queue_empty);
				fails++;
			end
		endfunction
	endclass

endpackage

/* bench/round_robin_time_slicer_core_tb.sv */
// regression bench for round_robin_time_slicer_core with a queue-model scoreboard
module round_robin_time_slicer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rrts_pkg::*;
	import rrts_ledger_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 11;
	localparam int PHASE_ITEMS = 100;

	logic clk;
	logic arst_n;

	rrts_item_if   item_ch();
	rrts_result_if result_ch();
	rrts_cfg_if    cfg_ch();

	round_robin_time_slicer_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	slice_ledger ledger = new(QUEUE_DEPTH);
	bit          steady;
	int unsigned cur_quantum;
	int          stall_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		if (steady)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// bursts mostly a few quanta long so words cycle through the queue
	function automatic logic [15:0] pick_burst();
		int unsigned span;
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom_range(0, 65535));
		span = cur_quantum * $urandom_range(0, 3) + $urandom_range(0, 3);
		if (span > 65535)
			span = $urandom_range(0, 65535);
		return span[15:0];
	endfunction

	// entered at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic op, input logic [7:0] pid, input logic [15:0] burst);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= op;
		item_ch.process_id <= pid;
		item_ch.burst_time <= burst;
		do @(posedge clk); while (!item_ch.ready);
		ledger.log_item(op, pid, burst);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (ledger.pending() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_quantum(input logic [15:0] value);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.time_quantum <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		ledger.set_quantum(value);
		cur_quantum = 32'(value);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		int load_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 2))
					0: load_pct = 25;
					1: load_pct = 50;
					default: load_pct = 80;
				endcase
			end
			if ($urandom_range(1, 100) <= load_pct)
				send_item(OP_LOAD, 8'($urandom_range(0, 255)), pick_burst());
			else
				send_item(OP_SLICE, 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)));
		end
	endtask

	// result side: random stall ahead of each word
	initial begin
		int   gap;
		outcome_t got;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got.served_id = result_ch.served_id;
			got.remaining_time = result_ch.remaining_time;
			got.status = result_ch.status;
			got.queue_empty = result_ch.queue_empty;
			ledger.check_result(got);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("round_robin_time_slicer_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] q;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.opcode <= OP_LOAD;
		item_ch.process_id <= '0;
		item_ch.burst_time <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.time_quantum <= 16'd1;
		stall_cycles <= 0;
		steady = 1'b0;
		cur_quantum = 1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty queue, zero burst, single-entry requeue, fill, refusal
		send_item(OP_SLICE, 8'h00, 16'h0000);
		send_item(OP_LOAD, 8'h00, 16'h0000);
		send_item(OP_SLICE, 8'hff, 16'hffff);
		send_item(OP_LOAD, 8'hff, 16'hffff);
		send_item(OP_SLICE, 8'h00, 16'h0000);
		send_item(OP_SLICE, 8'h5a, 16'h5a5a);
		send_item(OP_LOAD, 8'ha5, 16'd2);
		for (int i = 0; i < QUEUE_DEPTH - 2; i++)
			send_item(OP_LOAD, 8'(i * 17 + 1), 16'(i * 4681 + 3));
		send_item(OP_LOAD, 8'h3c, 16'hc3c3);
		// widest quantum finishes the long burst, zero quantum requeues unchanged
		write_quantum(16'hffff);
		send_item(OP_SLICE, 8'h00, 16'h0000);
		write_quantum(16'h0000);
		send_item(OP_SLICE, 8'h00, 16'h0000);
		send_item(OP_SLICE, 8'h00, 16'h0000);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: q = 16'd1;
				1: q = 16'hffff;
				2: q = 16'h0000;
				default: begin
					if ($urandom_range(0, 1) == 0)
						q = 16'($urandom_range(1, 16));
					else
						q = 16'($urandom_range(1, 65535));
				end
			endcase
			write_quantum(q);
			random_phase(PHASE_ITEMS);
		end

		steady = 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		if (ledger.fails == 0)
			$display("round_robin_time_slicer_core regression: pass");
		else
			$display("round_robin_time_slicer_core regression: fail");
		$finish;
	end

endmodule

/* round_robin_time_slicer_core.f */
rtl/rrts_pkg.sv
rtl/rrts_if.sv
rtl/rrts_cell.sv
rtl/round_robin_time_slicer_core.sv
rtl/rrts_checker.sv
bench/rrts_ledger_pkg.sv
bench/round_robin_time_slicer_core_tb.sv
